### hdl/ppg_pkg.sv
// package for the periodic pulse generator: widths, register codes, reset values,
// controller states and the command/status bundles between controller and datapath
// no dependencies
package ppg_pkg;

  // field widths
  localparam int TIME_W     = 24;
  localparam int AMP_W      = 16;
  localparam int QUO_W      = AMP_W;
  localparam int DIV_CNT_W  = $clog2(QUO_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd4;

  // register reset values
  localparam logic [TIME_W-1:0] PERIOD_RST = 24'd1000;
  localparam logic [TIME_W-1:0] DELAY_RST  = 24'd500;
  localparam logic [TIME_W-1:0] WIDTH_RST  = 24'd500;
  localparam logic              SHAPE_RST  = 1'b0;
  localparam logic [AMP_W-1:0]  AMP_RST    = 16'd1024;

  // shape codes
  localparam logic SHAPE_RECT = 1'b0;
  localparam logic SHAPE_TRI  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic step;      // advance counters with the accepted transaction
    logic mul;       // form amplitude * distance and load the divider
    logic div;       // one restoring divide step
    logic load_out;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic tri_pending;  // current sample needs the triangle slope
    logic div_last;     // final divide step in progress
    logic out_full;     // output register holds a transaction that is stalled
  } status_t;

endpackage

### hdl/ppg_ctrl.sv
// controller state machine of the periodic pulse generator
// depends on ppg_pkg; drives commands to ppg_datapath and the input stall
module ppg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppg_pkg::status_t   status,
  output ppg_pkg::cmd_t      cmd
);

  ppg_pkg::state_t state_r;
  ppg_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ppg_pkg::ST_CALC;
      end
      ppg_pkg::ST_CALC: begin
        state_nxt = status.tri_pending ? ppg_pkg::ST_DIV : ppg_pkg::ST_DONE;
      end
      ppg_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = ppg_pkg::ST_DONE;
      end
      ppg_pkg::ST_DONE: begin
        if (!status.out_full) state_nxt = ppg_pkg::ST_IDLE;
      end
      default: state_nxt = ppg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ppg_pkg::ST_IDLE: begin
        in_stall = !rst_n;
        cmd.step = in_valid && rst_n;
      end
      ppg_pkg::ST_CALC: begin
        cmd.mul = status.tri_pending;
      end
      ppg_pkg::ST_DIV: begin
        cmd.div = 1'b1;
      end
      ppg_pkg::ST_DONE: begin
        cmd.load_out = !status.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/ppg_datapath.sv
// datapath of the periodic pulse generator: delay and phase counters, slope
// multiplier, 16-step restoring divider and output register; depends on ppg_pkg
module ppg_datapath #(
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ppg_pkg::cmd_t                cmd,
  output ppg_pkg::status_t             status,
  input  logic [ppg_pkg::TIME_W-1:0]   period_ticks,
  input  logic [ppg_pkg::TIME_W-1:0]   delay_ticks,
  input  logic [ppg_pkg::TIME_W-1:0]   width_ticks,
  input  logic                         shape_mode,
  input  logic [ppg_pkg::AMP_W-1:0]    amplitude,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppg_pkg::AMP_W-1:0]    out_sample_value,
  output logic                         out_in_pulse
);

  // compare width covers both the counters and the time registers
  localparam int PW = (COUNT_BITS > ppg_pkg::TIME_W) ? COUNT_BITS : ppg_pkg::TIME_W;
  localparam int TW = ppg_pkg::TIME_W;
  localparam int AW = ppg_pkg::AMP_W;
  localparam int QW = ppg_pkg::QUO_W;
  localparam int CW = ppg_pkg::DIV_CNT_W;

  logic [COUNT_BITS-1:0] delay_count_r, delay_count_nxt;
  logic                  delay_done_r,  delay_done_nxt;
  logic [COUNT_BITS-1:0] phase_count_r, phase_count_nxt;
  logic                  pulse_r,       pulse_nxt;
  logic                  tri_r,         tri_nxt;
  logic [TW-1:0]         dist_r,        dist_nxt;
  logic [TW-1:0]         rem_r,         rem_nxt;
  logic [QW-1:0]         quo_r,         quo_nxt;
  logic [CW-1:0]         cnt_r,         cnt_nxt;
  logic                  out_valid_r,   out_valid_nxt;
  logic [AW-1:0]         out_value_r,   out_value_nxt;
  logic                  out_pulse_r,   out_pulse_nxt;

  logic [COUNT_BITS-1:0] dc, pc, phase;
  logic                  dd;
  logic [TW:0]           twice, width_ext, trial;
  logic                  ge;
  logic [TW+AW-1:0]      prod;

  // counter step for one accepted transaction
  always_comb begin
    dc = in_restart ? '0 : delay_count_r;
    pc = in_restart ? '0 : phase_count_r;
    dd = in_restart ? 1'b0 : delay_done_r;

    if (PW'(pc) >= PW'(period_ticks)) begin
      phase = COUNT_BITS'(1);
    end else begin
      phase = pc + COUNT_BITS'(1);
    end

    delay_count_nxt = delay_count_r;
    delay_done_nxt  = delay_done_r;
    phase_count_nxt = phase_count_r;
    pulse_nxt       = pulse_r;
    tri_nxt         = tri_r;
    dist_nxt        = dist_r;

    if (cmd.step) begin
      delay_count_nxt = dc;
      delay_done_nxt  = dd;
      phase_count_nxt = pc;
      pulse_nxt       = 1'b0;
      tri_nxt         = 1'b0;
      if (!dd) begin
        if ((PW'(dc) >= PW'(delay_ticks)) || (&dc)) begin
          delay_done_nxt  = 1'b1;
          phase_count_nxt = '0;
        end else begin
          delay_count_nxt = dc + COUNT_BITS'(1);
        end
      end else begin
        phase_count_nxt = phase;
        pulse_nxt       = PW'(phase) < PW'(width_ticks);
        tri_nxt         = pulse_nxt && (shape_mode == ppg_pkg::SHAPE_TRI);
      end
      // twice the distance from the pulse center, only used inside the pulse
      twice     = (TW + 1)'({PW'(phase), 1'b0});
      width_ext = {1'b0, width_ticks};
      dist_nxt  = (twice > width_ext) ? TW'(twice - width_ext) : TW'(width_ext - twice);
    end else begin
      twice     = '0;
      width_ext = {1'b0, width_ticks};
    end
  end

  // slope multiply and restoring divide by the width
  always_comb begin
    prod    = (TW + AW)'(amplitude) * (TW + AW)'(dist_r);
    trial   = {rem_r, quo_r[QW-1]};
    ge      = trial >= {1'b0, width_ticks};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (cmd.mul) begin
      rem_nxt = prod[TW+AW-1:AW];
      quo_nxt = prod[QW-1:0];
      cnt_nxt = '0;
    end else if (cmd.div) begin
      rem_nxt = ge ? TW'(trial - {1'b0, width_ticks}) : trial[TW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_pulse_nxt = out_pulse_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_pulse_nxt = pulse_r;
      if (!pulse_r) begin
        out_value_nxt = '0;
      end else if (tri_r) begin
        out_value_nxt = amplitude - quo_r;
      end else begin
        out_value_nxt = amplitude;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_count_r <= '0;
      delay_done_r  <= 1'b0;
      phase_count_r <= '0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      delay_count_r <= delay_count_nxt;
      delay_done_r  <= delay_done_nxt;
      phase_count_r <= phase_count_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pulse_r     <= pulse_nxt;
    tri_r       <= tri_nxt;
    dist_r      <= dist_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    out_value_r <= out_value_nxt;
    out_pulse_r <= out_pulse_nxt;
  end

  always_comb begin
    status.tri_pending = tri_r;
    status.div_last    = (cnt_r == CW'(QW - 1));
    status.out_full    = out_valid_r && out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_in_pulse     = out_pulse_r;

endmodule

### hdl/periodic_pulse_generator_core.sv
// periodic pulse generator, one item at a time: rectangle and zero samples reach the
// output register through the CALC and DONE states, triangle samples through CALC, the
// restoring divider by width_ticks (one multiply in CALC, 16 divide steps) and DONE
// next transaction taken in IDLE after the load; DONE holds while the output is stalled
// reset (synchronous, rst_n low) loads the register defaults and clears the counters
// depends on ppg_pkg, ppg_ctrl, ppg_datapath
module periodic_pulse_generator_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ppg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ppg_pkg::AMP_W-1:0]          out_sample_value,
  output logic                               out_in_pulse
);

  logic [ppg_pkg::TIME_W-1:0] period_ticks_r;
  logic [ppg_pkg::TIME_W-1:0] delay_ticks_r;
  logic [ppg_pkg::TIME_W-1:0] width_ticks_r;
  logic                       shape_mode_r;
  logic [ppg_pkg::AMP_W-1:0]  amplitude_r;

  ppg_pkg::cmd_t    cmd;
  ppg_pkg::status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r <= ppg_pkg::PERIOD_RST;
      delay_ticks_r  <= ppg_pkg::DELAY_RST;
      width_ticks_r  <= ppg_pkg::WIDTH_RST;
      shape_mode_r   <= ppg_pkg::SHAPE_RST;
      amplitude_r    <= ppg_pkg::AMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppg_pkg::REG_PERIOD: period_ticks_r <= cfg_wdata[ppg_pkg::TIME_W-1:0];
        ppg_pkg::REG_DELAY:  delay_ticks_r  <= cfg_wdata[ppg_pkg::TIME_W-1:0];
        ppg_pkg::REG_WIDTH:  width_ticks_r  <= cfg_wdata[ppg_pkg::TIME_W-1:0];
        ppg_pkg::REG_SHAPE:  shape_mode_r   <= cfg_wdata[0];
        ppg_pkg::REG_AMP:    amplitude_r    <= cfg_wdata[ppg_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  ppg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ppg_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .period_ticks     (period_ticks_r),
    .delay_ticks      (delay_ticks_r),
    .width_ticks      (width_ticks_r),
    .shape_mode       (shape_mode_r),
    .amplitude        (amplitude_r),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_in_pulse     (out_in_pulse)
  );

  // samples outside the pulse are zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_pulse |-> out_sample_value == '0)
    else $error("nonzero sample outside the pulse");

  // a sample never exceeds the amplitude
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_pulse |-> out_sample_value <= amplitude_r)
    else $error("sample above amplitude");

  // rectangle pulses sit at full amplitude
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_pulse && (shape_mode_r == ppg_pkg::SHAPE_RECT)
      |-> out_sample_value == amplitude_r)
    else $error("rectangle sample not at amplitude");

  // no transaction is taken while the divider is working
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> in_stall)
    else $error("input accepted during divide");

endmodule
